@@ rtl/core/event_grouped_weighted_histogram_assert.svh @@
// assertion macros for the histogram core
`ifndef EVENT_GROUPED_WEIGHTED_HISTOGRAM_ASSERT_SVH
`define EVENT_GROUPED_WEIGHTED_HISTOGRAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EWH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ewh: assertion failed");
`define EWH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ewh: assertion failed");
`else
`define EWH_ASSERT_NEXT(lbl, ante, cons)
`define EWH_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

@@ rtl/core/ewh_pkg.sv @@
// shared constants and controller/datapath interface types of the histogram core
package ewh_pkg;
	localparam int NUM_BINS_DEF = 64;
	localparam int PEND_DEPTH = 64;
	localparam int PEND_AW = 6;
	localparam int PEND_CW = 7;
	localparam int ADDR_W = 4;

	localparam logic [1:0] OP_FILL = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam logic [1:0] REG_RANGE_LOW = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_BIN_SCALE = 2'd2;
	localparam logic [1:0] REG_BINS_IN_USE = 2'd3;

	localparam logic [31:0] RANGE_LOW_RST = 32'h0000_0000;
	localparam logic [31:0] RANGE_HIGH_RST = 32'h7FFF_FFFF;
	localparam logic [31:0] BIN_SCALE_RST = 32'h0001_0000;
	localparam logic [6:0] BINS_IN_USE_RST = 7'd64;

	localparam logic [39:0] PW_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [39:0] PW_MIN = 40'h80_0000_0000;
	localparam logic [63:0] WS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] WS_MIN = 64'h8000_0000_0000_0000;
	localparam logic [62:0] SQ_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FILL,
		RES_READ
	} res_sel_t;

	typedef struct packed {
		logic accept;
		logic set_event;
		logic cm_start;
		logic cm_list_rd;
		logic cm_rd;
		logic cm_wr;
		logic cm_done;
		logic fill_rd;
		logic fill_wr;
		logic read_rd;
		logic clear_wr;
		logic res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic in_ok;
		logic new_event;
		logic cm_more;
		logic clear_last;
		logic out_free;
	} sts_t;
endpackage

@@ rtl/core/ewh_regs.sv @@
// configuration register file behind the apb port
module ewh_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ewh_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic signed [31:0]          range_low,
	output logic signed [31:0]          range_high,
	output logic [31:0]                 bin_scale,
	output logic [6:0]                  bins_in_use
);
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low <= ewh_pkg::RANGE_LOW_RST;
			range_high <= ewh_pkg::RANGE_HIGH_RST;
			bin_scale <= ewh_pkg::BIN_SCALE_RST;
			bins_in_use <= ewh_pkg::BINS_IN_USE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ewh_pkg::REG_RANGE_LOW: range_low <= pwdata;
				ewh_pkg::REG_RANGE_HIGH: range_high <= pwdata;
				ewh_pkg::REG_BIN_SCALE: bin_scale <= pwdata;
				ewh_pkg::REG_BINS_IN_USE: bins_in_use <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ewh_pkg::REG_RANGE_LOW: prdata = range_low;
			ewh_pkg::REG_RANGE_HIGH: prdata = range_high;
			ewh_pkg::REG_BIN_SCALE: prdata = bin_scale;
			ewh_pkg::REG_BINS_IN_USE: prdata = {25'd0, bins_in_use};
			default: prdata = '0;
		endcase
	end
endmodule

@@ rtl/core/ewh_ctrl.sv @@
// sequencing state machine of the histogram core
module ewh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  ewh_pkg::sts_t sts,
	output ewh_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_BIN,
		S_DEC,
		S_CM_LIST,
		S_CM_RD,
		S_CM_MUL,
		S_CM_WR,
		S_FILL_RD,
		S_FILL_WR,
		S_READ_RD,
		S_OUT
	} state_t;

	state_t state_q;
	ewh_pkg::res_sel_t res_sel_q;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.res_sel = res_sel_q;
		unique case (state_q)
			S_CLEAR: cmd.clear_wr = 1'b1;
			S_IDLE: cmd.accept = item_valid;
			S_DEC: begin
				if (sts.op == ewh_pkg::OP_FILL) begin
					if (sts.in_ok && sts.new_event) begin
						cmd.set_event = 1'b1;
						cmd.cm_start = 1'b1;
					end
				end else if (sts.op == ewh_pkg::OP_READ || sts.op == ewh_pkg::OP_FLUSH) begin
					cmd.cm_start = 1'b1;
				end
			end
			S_CM_LIST: begin
				if (sts.cm_more) begin
					cmd.cm_list_rd = 1'b1;
				end else begin
					cmd.cm_done = 1'b1;
				end
			end
			S_CM_RD: cmd.cm_rd = 1'b1;
			S_CM_WR: cmd.cm_wr = 1'b1;
			S_FILL_RD: cmd.fill_rd = 1'b1;
			S_FILL_WR: cmd.fill_wr = 1'b1;
			S_READ_RD: cmd.read_rd = 1'b1;
			S_OUT: cmd.res_load = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_sel_q <= ewh_pkg::RES_ZERO;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clear_last) state_q <= S_IDLE;
				S_IDLE: if (item_valid) state_q <= S_CALC;
				S_CALC: state_q <= S_BIN;
				S_BIN: state_q <= S_DEC;
				S_DEC: begin
					unique case (sts.op)
						ewh_pkg::OP_FILL: begin
							if (!sts.in_ok) begin
								res_sel_q <= ewh_pkg::RES_ZERO;
								state_q <= S_OUT;
							end else if (sts.new_event) begin
								state_q <= S_CM_LIST;
							end else begin
								state_q <= S_FILL_RD;
							end
						end
						ewh_pkg::OP_READ, ewh_pkg::OP_FLUSH: state_q <= S_CM_LIST;
						default: begin
							res_sel_q <= ewh_pkg::RES_ZERO;
							state_q <= S_OUT;
						end
					endcase
				end
				S_CM_LIST: begin
					if (sts.cm_more) begin
						state_q <= S_CM_RD;
					end else if (sts.op == ewh_pkg::OP_FILL) begin
						state_q <= S_FILL_RD;
					end else if (sts.op == ewh_pkg::OP_READ) begin
						state_q <= S_READ_RD;
					end else begin
						res_sel_q <= ewh_pkg::RES_ZERO;
						state_q <= S_OUT;
					end
				end
				S_CM_RD: state_q <= S_CM_MUL;
				S_CM_MUL: state_q <= S_CM_WR;
				S_CM_WR: state_q <= S_CM_LIST;
				S_FILL_RD: state_q <= S_FILL_WR;
				S_FILL_WR: begin
					res_sel_q <= ewh_pkg::RES_FILL;
					state_q <= S_OUT;
				end
				S_READ_RD: begin
					res_sel_q <= ewh_pkg::RES_READ;
					state_q <= S_OUT;
				end
				S_OUT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/ewh_dp.sv @@
// datapath: binning, pending list, bin totals memories and result register
module ewh_dp #(
	parameter int NUM_BINS = ewh_pkg::NUM_BINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ewh_pkg::cmd_t       cmd,
	output ewh_pkg::sts_t       sts,
	input  logic signed [31:0]  range_low,
	input  logic signed [31:0]  range_high,
	input  logic [31:0]         bin_scale,
	input  logic [6:0]          bins_in_use,
	input  logic [1:0]          opcode,
	input  logic [31:0]         event_id,
	input  logic signed [31:0]  sample_x,
	input  logic signed [31:0]  weight,
	input  logic [5:0]          read_bin,
	input  logic                res_stall,
	output logic                res_valid,
	output logic [5:0]          bin_index,
	output logic                in_range,
	output logic signed [63:0]  weight_sum,
	output logic [62:0]         weight_sq_sum,
	output logic [31:0]         event_count
);
	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [31:0] NB32 = 32'(NUM_BINS);

	typedef struct packed {
		logic [63:0] ws;
		logic [62:0] sq;
		logic [31:0] cnt;
	} tot_t;

	typedef struct packed {
		logic        mark;
		logic [39:0] pw;
	} pend_t;

	tot_t            tot_mem [NUM_BINS];
	pend_t           pend_mem [NUM_BINS];
	logic [BIN_W-1:0] list_mem [ewh_pkg::PEND_DEPTH];

	// captured item
	logic [1:0]         op_q;
	logic [31:0]        evt_q;
	logic signed [31:0] x_q;
	logic [31:0]        w_q;
	logic [5:0]         rb_q;

	logic [32:0]        diff_c;
	logic               in_ok_c;
	logic               ok_s1;
	logic [63:0]        prod_s1;
	logic [31:0]        used_c;
	logic [31:0]        hi_c;
	logic [31:0]        bfull_c;
	logic [BIN_W-1:0]   b_s2;

	logic [31:0]        last_q;
	logic               seen_q;
	logic [ewh_pkg::PEND_CW-1:0] pend_count_q;
	logic [ewh_pkg::PEND_CW-1:0] cm_idx_q;
	logic [BIN_W-1:0]   clr_idx_q;
	logic [BIN_W-1:0]   cm_bin_q;
	logic               list_room;

	logic [BIN_W-1:0]   pend_addr;
	logic [BIN_W-1:0]   tot_addr;
	logic [BIN_W+5:0]   rb_ext;
	logic [BIN_W-1:0]   rb_idx;
	logic               rb_ok;
	pend_t              pend_rd_q;
	tot_t               tot_rd_q;

	logic [39:0]        mag_c;
	logic [63:0]        sq_full_c;
	logic [62:0]        sq_q;
	logic [63:0]        add_c;
	logic [64:0]        ws_sum_c;
	logic [63:0]        sq_sum_c;
	tot_t               tot_new_c;
	logic [40:0]        ps_c;
	logic [39:0]        ps_sat_c;
	logic               fill_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= opcode;
			evt_q <= event_id;
			x_q <= sample_x;
			w_q <= weight;
			rb_q <= read_bin;
		end
	end

	// range check and bin product, then clamp to bins in use
	assign diff_c = {x_q[31], x_q} - {range_low[31], range_low};
	assign in_ok_c = (x_q >= range_low) && (x_q < range_high);

	always_comb begin
		used_c = {25'd0, bins_in_use};
		if (used_c == 32'd0) used_c = 32'd1;
		if (used_c > NB32) used_c = NB32;
		hi_c = prod_s1[63:32];
		bfull_c = (hi_c > used_c - 32'd1) ? (used_c - 32'd1) : hi_c;
	end

	always_ff @(posedge clk) begin
		ok_s1 <= in_ok_c;
		prod_s1 <= 64'(diff_c[31:0]) * 64'(bin_scale);
		b_s2 <= bfull_c[BIN_W-1:0];
	end

	assign rb_ext = (BIN_W + 6)'(rb_q);
	assign rb_idx = rb_ext[BIN_W-1:0];
	assign rb_ok = (32'(rb_q) < NB32);
	assign list_room = (pend_count_q < ewh_pkg::PEND_CW'(ewh_pkg::PEND_DEPTH));

	assign pend_addr = cmd.fill_rd ? b_s2 : cm_bin_q;
	assign tot_addr = cmd.read_rd ? rb_idx : cm_bin_q;

	always_ff @(posedge clk) begin
		if (cmd.fill_rd || cmd.cm_rd) pend_rd_q <= pend_mem[pend_addr];
		if (cmd.read_rd || cmd.cm_rd) tot_rd_q <= tot_mem[tot_addr];
		if (cmd.cm_list_rd) cm_bin_q <= list_mem[cm_idx_q[ewh_pkg::PEND_AW-1:0]];
	end

	// squared pending weight, saturated to 63 bits
	always_comb begin
		mag_c = pend_rd_q.pw[39] ? (40'd0 - pend_rd_q.pw) : pend_rd_q.pw;
		sq_full_c = 64'(mag_c[31:0]) * 64'(mag_c[31:0]);
	end

	always_ff @(posedge clk) begin
		sq_q <= ((|mag_c[39:32]) || sq_full_c[63]) ? ewh_pkg::SQ_MAX : sq_full_c[62:0];
	end

	always_comb begin
		add_c = {{8{pend_rd_q.pw[39]}}, pend_rd_q.pw, 16'd0};
		ws_sum_c = {tot_rd_q.ws[63], tot_rd_q.ws} + {add_c[63], add_c};
		sq_sum_c = {1'b0, tot_rd_q.sq} + {1'b0, sq_q};
		if (ws_sum_c[64] != ws_sum_c[63]) begin
			tot_new_c.ws = ws_sum_c[64] ? ewh_pkg::WS_MIN : ewh_pkg::WS_MAX;
		end else begin
			tot_new_c.ws = ws_sum_c[63:0];
		end
		tot_new_c.sq = sq_sum_c[63] ? ewh_pkg::SQ_MAX : sq_sum_c[62:0];
		tot_new_c.cnt = (&tot_rd_q.cnt) ? tot_rd_q.cnt : tot_rd_q.cnt + 32'd1;
		ps_c = {pend_rd_q.pw[39], pend_rd_q.pw} + {{9{w_q[31]}}, w_q};
		if (ps_c[40] != ps_c[39]) begin
			ps_sat_c = ps_c[40] ? ewh_pkg::PW_MIN : ewh_pkg::PW_MAX;
		end else begin
			ps_sat_c = ps_c[39:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			tot_mem[clr_idx_q] <= '0;
			pend_mem[clr_idx_q] <= '0;
		end else if (cmd.cm_wr) begin
			tot_mem[cm_bin_q] <= tot_new_c;
			pend_mem[cm_bin_q] <= '0;
		end else if (cmd.fill_wr) begin
			if (pend_rd_q.mark) begin
				pend_mem[b_s2] <= '{mark: 1'b1, pw: ps_sat_c};
			end else if (list_room) begin
				pend_mem[b_s2] <= '{mark: 1'b1, pw: {{8{w_q[31]}}, w_q}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_wr && !pend_rd_q.mark && list_room) begin
			list_mem[pend_count_q[ewh_pkg::PEND_AW-1:0]] <= b_s2;
		end
		if (cmd.fill_wr) fill_ok_q <= pend_rd_q.mark || list_room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			seen_q <= 1'b0;
			pend_count_q <= '0;
			cm_idx_q <= '0;
			clr_idx_q <= '0;
		end else begin
			if (cmd.set_event) begin
				last_q <= evt_q;
				seen_q <= 1'b1;
			end
			if (cmd.cm_done) begin
				pend_count_q <= '0;
			end else if (cmd.fill_wr && !pend_rd_q.mark && list_room) begin
				pend_count_q <= pend_count_q + 1'b1;
			end
			if (cmd.cm_start) begin
				cm_idx_q <= '0;
			end else if (cmd.cm_wr) begin
				cm_idx_q <= cm_idx_q + 1'b1;
			end
			if (cmd.clear_wr) clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			bin_index <= '0;
			in_range <= 1'b0;
			weight_sum <= '0;
			weight_sq_sum <= '0;
			event_count <= '0;
			unique case (cmd.res_sel)
				ewh_pkg::RES_FILL: begin
					bin_index <= 6'(b_s2);
					in_range <= fill_ok_q;
				end
				ewh_pkg::RES_READ: begin
					bin_index <= rb_q;
					if (rb_ok) begin
						weight_sum <= tot_rd_q.ws;
						weight_sq_sum <= tot_rd_q.sq;
						event_count <= tot_rd_q.cnt;
					end
				end
				default: ;
			endcase
		end
	end

	assign sts.op = op_q;
	assign sts.in_ok = ok_s1;
	assign sts.new_event = !seen_q || (evt_q != last_q);
	assign sts.cm_more = (cm_idx_q < pend_count_q);
	assign sts.clear_last = (clr_idx_q == BIN_W'(NUM_BINS - 1));
	assign sts.out_free = !res_valid || !res_stall;
endmodule

@@ rtl/core/event_grouped_weighted_histogram.sv @@
// top level of the event-grouped weighted histogram
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    opcode event_id sample_x weight read_bin
//   result    out        res_valid / res_stall      bin_index in_range weight_sum
//                                                   weight_sq_sum event_count
//   config    in         apb psel/penable/pwrite    paddr pwdata, prdata back
//
// after reset a clearing pass zeroes the NUM_BINS entries of the bin memories; items stall
// until their result is loaded: a fill of the current event reads and writes its pending entry,
// a rejected sample or unused opcode goes straight to the result; a fill opening a new event,
// a read and a flush first fold all P pending entries into the bin totals, one memory pass each
// one item at a time; the next beat is taken while the last result still waits
// a held result only stalls the next item at its final step
`include "event_grouped_weighted_histogram_assert.svh"
module event_grouped_weighted_histogram #(
	parameter int NUM_BINS = ewh_pkg::NUM_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ewh_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [1:0]                  opcode,
	input  logic [31:0]                 event_id,
	input  logic signed [31:0]          sample_x,
	input  logic signed [31:0]          weight,
	input  logic [5:0]                  read_bin,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [5:0]                  bin_index,
	output logic                        in_range,
	output logic signed [63:0]          weight_sum,
	output logic [62:0]                 weight_sq_sum,
	output logic [31:0]                 event_count
);
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;
	logic [31:0]        bin_scale;
	logic [6:0]         bins_in_use;
	ewh_pkg::cmd_t      cmd;
	ewh_pkg::sts_t      sts;

	ewh_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.range_low   (range_low),
		.range_high  (range_high),
		.bin_scale   (bin_scale),
		.bins_in_use (bins_in_use)
	);

	ewh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ewh_dp #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.range_low     (range_low),
		.range_high    (range_high),
		.bin_scale     (bin_scale),
		.bins_in_use   (bins_in_use),
		.opcode        (opcode),
		.event_id      (event_id),
		.sample_x      (sample_x),
		.weight        (weight),
		.read_bin      (read_bin),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.bin_index     (bin_index),
		.in_range      (in_range),
		.weight_sum    (weight_sum),
		.weight_sq_sum (weight_sq_sum),
		.event_count   (event_count)
	);

	`EWH_ASSERT_NEXT(a_one_item, item_valid && !item_stall, item_stall)
	`EWH_ASSERT_NEXT(a_res_shown, cmd.res_load, res_valid)
	`EWH_ASSERT_SAME(a_no_overwrite, cmd.res_load, !res_valid || !res_stall)
	`EWH_ASSERT_SAME(a_clear_idle, cmd.clear_wr, item_stall && !res_valid)
endmodule
